[rtl/core/rrbc_pkg.sv]
// ----------------------------------------------------------------------------
// Rotor reflector byte cipher package
// Shared types and constants for the front end, the request queue and the
// table pipeline.
// ----------------------------------------------------------------------------
package rrbc_pkg;

  // Table depth and index width of the rotor machine.
  localparam int unsigned RotorSize = 256;
  localparam int unsigned IdxW      = $clog2(RotorSize);

  typedef logic [IdxW-1:0] byte_t;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_POSITION = 2'd1,
    CMD_CIPHER   = 2'd2
  } cmd_e;

  // Table selection for load requests.
  typedef enum logic [1:0] {
    SEL_ROTOR   = 2'd0,
    SEL_INVERSE = 2'd1,
    SEL_REFLECT = 2'd2
  } sel_e;

  // One operation handed from the front end to the table pipeline.
  // For a load, addr is the table index and val the byte to write.
  // For a cipher request, addr is the rotor index (data plus fast offset)
  // and fast and slow are the positions that apply to this byte.
  typedef struct packed {
    logic  is_cipher;
    sel_e  sel;
    byte_t addr;
    byte_t val;
    byte_t fast;
    byte_t slow;
  } op_t;

endpackage

[rtl/core/rotor_reflector_byte_cipher_core.sv]
// ----------------------------------------------------------------------------
// Rotor reflector byte cipher core
// One-rotor machine with rotor, reflector and inverse rotor tables.
// ----------------------------------------------------------------------------
// A cipher request leaves the request queue and passes the rotor read, the
// reflector read and the inverse read; the final offset then goes into the
// result register. Throughput: one request per cycle unless a waiting result
// stalls the pipeline, limited by the single read port of each of the three
// 256-entry tables, which sit in successive pipeline stages.
// Reset: the position counters clear to zero and the queue, the pipeline and
// the result register empty; the tables are not cleared and must be loaded.
// ----------------------------------------------------------------------------
module rotor_reflector_byte_cipher_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [1:0]  table_select_i,
  input  logic [7:0]  table_index_i,
  input  logic [7:0]  table_value_i,
  input  logic [15:0] start_position_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  result_byte_o
);
  import rrbc_pkg::*;

  // The front end handles position requests on its own and drops requests
  // that do nothing. Loads and cipher requests go through the queue, each
  // cipher request carrying the counter values in force when it was taken,
  // so the pipeline never has to look back at the counters.
  logic q_push, q_full, q_pop, q_empty;
  op_t  q_in_op, q_out_op;

  rrbc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .cmd_i            (cmd_i),
    .table_select_i   (table_select_i),
    .table_index_i    (table_index_i),
    .table_value_i    (table_value_i),
    .start_position_i (start_position_i),
    .data_byte_i      (data_byte_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_op_o           (q_in_op)
  );

  // The queue lets requests keep arriving while the result side stalls.
  rrbc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (q_in_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .op_o    (q_out_op)
  );

  // The table pipeline writes each table in the same stage that reads it,
  // which keeps loads and cipher requests in order without interlocks.
  rrbc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_op_i        (q_out_op),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .result_byte_o (result_byte_o)
  );

  // The pipeline never takes from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_pop && q_empty))
    else $error("pipeline popped an empty request queue");

  // The front end never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("front end pushed into a full request queue");

  // A stalled result stays put until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_byte_o)))
    else $error("result changed while waiting to be taken");

  // A request is only taken by the front end when the queue has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (full == q_full))
    else $error("full flag does not follow the request queue");

endmodule

[rtl/core/rrbc_front.sv]
// ----------------------------------------------------------------------------
// Rotor reflector front end
// Accepts requests, keeps the stream position counters and forwards table
// loads and cipher requests, tagged with their positions, to the queue.
// ----------------------------------------------------------------------------
module rrbc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [1:0]       cmd_i,
  input  logic [1:0]       table_select_i,
  input  logic [7:0]       table_index_i,
  input  logic [7:0]       table_value_i,
  input  logic [15:0]      start_position_i,
  input  logic [7:0]       data_byte_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output rrbc_pkg::op_t    q_op_o
);
  import rrbc_pkg::*;

  byte_t fast_q, fast_d;
  byte_t slow_q, slow_d;
  logic  accept;

  assign full_o = q_full_i;
  assign accept = push_i && !q_full_i;

  always_comb begin
    fast_d             = fast_q;
    slow_d             = slow_q;
    q_push_o           = 1'b0;
    q_op_o.is_cipher   = 1'b0;
    q_op_o.sel         = SEL_ROTOR;
    q_op_o.addr        = table_index_i;
    q_op_o.val         = table_value_i;
    q_op_o.fast        = fast_q;
    q_op_o.slow        = slow_q;
    unique case (cmd_i)
      CMD_LOAD: begin
        // A load with an unused table select is dropped here.
        unique case (table_select_i) inside
          SEL_ROTOR, SEL_INVERSE, SEL_REFLECT: begin
            q_push_o   = accept;
            q_op_o.sel = sel_e'(table_select_i);
          end
          default: q_push_o = 1'b0;
        endcase
      end
      CMD_POSITION: begin
        if (accept) begin
          fast_d = start_position_i[IdxW-1:0];
          slow_d = start_position_i[2*IdxW-1:IdxW];
        end
      end
      CMD_CIPHER: begin
        q_push_o         = accept;
        q_op_o.is_cipher = 1'b1;
        q_op_o.addr      = data_byte_i + fast_q;
        if (accept) begin
          fast_d = fast_q + 1'b1;
          if (fast_q == '1) begin
            slow_d = slow_q + 1'b1;
          end
        end
      end
      default: q_push_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= '0;
      slow_q <= '0;
    end else begin
      fast_q <= fast_d;
      slow_q <= slow_d;
    end
  end

endmodule

[rtl/core/rrbc_queue.sv]
// ----------------------------------------------------------------------------
// Rotor reflector request queue
// Small first-in first-out buffer of operations between the front end and
// the table pipeline. The depth must be a power of two.
// ----------------------------------------------------------------------------
module rrbc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rrbc_pkg::op_t    op_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output rrbc_pkg::op_t    op_o
);
  import rrbc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  op_t             entries_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign op_o    = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[rtl/core/rrbc_back.sv]
// ----------------------------------------------------------------------------
// Rotor reflector table pipeline
// Four stages: rotor access, reflector access, inverse access and the final
// offset. Each table is written at the stage that reads it, so loads and
// cipher requests see the tables in request order.
// ----------------------------------------------------------------------------
module rrbc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  rrbc_pkg::op_t    q_op_i,
  output logic             q_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [7:0]       result_byte_o
);
  import rrbc_pkg::*;

  byte_t rotor_mem   [RotorSize];
  byte_t reflect_mem [RotorSize];
  byte_t inverse_mem [RotorSize];

  byte_t rotor_rd_q, reflect_rd_q, inverse_rd_q;
  logic  s1_valid_q, s2_valid_q, s3_valid_q;
  op_t   s1_op_q, s2_op_q, s3_op_q;
  logic  out_valid_q;
  byte_t result_q;

  logic  advance;
  logic  s0_valid;
  byte_t s1_addr, s2_addr;

  // The whole pipeline moves whenever the output register can take a value.
  assign advance  = !out_valid_q || pop_i;
  assign s0_valid = !q_empty_i;
  assign q_pop_o  = advance && s0_valid;

  assign s1_addr = s1_op_q.is_cipher ? byte_t'(rotor_rd_q + s1_op_q.slow) : s1_op_q.addr;
  assign s2_addr = s2_op_q.is_cipher ? byte_t'(reflect_rd_q - s2_op_q.slow) : s2_op_q.addr;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (s0_valid && !q_op_i.is_cipher && q_op_i.sel == SEL_ROTOR) begin
        rotor_mem[q_op_i.addr] <= q_op_i.val;
      end
      rotor_rd_q <= rotor_mem[q_op_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (s1_valid_q && !s1_op_q.is_cipher && s1_op_q.sel == SEL_REFLECT) begin
        reflect_mem[s1_addr] <= s1_op_q.val;
      end
      reflect_rd_q <= reflect_mem[s1_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (s2_valid_q && !s2_op_q.is_cipher && s2_op_q.sel == SEL_INVERSE) begin
        inverse_mem[s2_addr] <= s2_op_q.val;
      end
      inverse_rd_q <= inverse_mem[s2_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_op_q  <= q_op_i;
      s2_op_q  <= s1_op_q;
      s3_op_q  <= s2_op_q;
      result_q <= inverse_rd_q - s3_op_q.fast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= s0_valid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q && s3_op_q.is_cipher;
    end
  end

  assign empty_o       = !out_valid_q;
  assign result_byte_o = result_q;

endmodule
